@@ hdl/apm_pkg.sv @@
// ----------------------------------------------------------------------------
// apm_pkg
// Types, constants and preset coefficient tables for the anaglyph mixer.
// ----------------------------------------------------------------------------
package apm_pkg;

   localparam int MODE_COUNT     = 12;
   localparam int COEF_FRAC_BITS = 10;
   localparam int TABLE_MODES    = 12;

   localparam int CHAN_W   = 8;
   localparam int COEF_W   = COEF_FRAC_BITS + 1;
   localparam int PROD_W   = CHAN_W + COEF_W;
   localparam int SUM_W    = CHAN_W + 2;
   localparam int MODE_W   = 4;
   localparam int IDX_W    = $clog2(TABLE_MODES);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = MODE_W;

   typedef logic [CHAN_W-1:0]     chan_type;
   typedef chan_type [2:0]        pixel_type;   // [0] red, [1] green, [2] blue
   typedef logic [COEF_W-1:0]     coef_type;
   typedef coef_type [2:0]        row_type;
   typedef row_type [2:0]         preset_type;  // [0] left red, [1] right green, [2] right blue
   typedef preset_type [TABLE_MODES-1:0] coef_table_type;
   typedef logic [MODE_W-1:0]     mode_type;
   typedef logic [IDX_W-1:0]      midx_type;
   typedef midx_type [2**MODE_W-1:0] mode_map_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef struct packed {
      mode_type mode;
      logic     swap_eyes;
   } cfg_type;

   localparam csr_idx_type REG_MODE = CSR_IDX_W'(0);
   localparam csr_idx_type REG_SWAP = CSR_IDX_W'(1);

   localparam logic [SUM_W-1:0]  CHAN_MAX   = SUM_W'(2**CHAN_W - 1);
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_FRAC_BITS - 1);

   // weights in thousandths: mode, row, color
   localparam int PRESET_K [TABLE_MODES][3][3] = '{
      '{'{1000, 0, 0},    '{0, 1000, 0},    '{0, 0, 1000}},
      '{'{299, 587, 114}, '{0, 0, 0},       '{299, 587, 114}},
      '{'{299, 587, 114}, '{299, 587, 114}, '{299, 587, 114}},
      '{'{299, 587, 114}, '{0, 1000, 0},    '{0, 0, 1000}},
      '{'{0, 700, 300},   '{0, 1000, 0},    '{0, 0, 1000}},
      '{'{0, 0, 0},       '{0, 0, 0},       '{0, 0, 1000}},
      '{'{0, 0, 0},       '{0, 1000, 0},    '{0, 0, 0}},
      '{'{1000, 0, 0},    '{0, 1000, 0},    '{0, 0, 0}},
      '{'{1000, 0, 0},    '{0, 0, 0},       '{0, 0, 1000}},
      '{'{0, 0, 0},       '{0, 0, 0},       '{0, 0, 1000}},
      '{'{299, 587, 114}, '{100, 100, 100}, '{299, 587, 114}},
      '{'{299, 587, 114}, '{300, 300, 300}, '{299, 587, 114}}
   };

   // round-half-up conversion to fixed point, evaluated at elaboration
   function automatic coef_table_type build_coefs();
      coef_table_type t;
      int k;
      t = '0;
      for (int m = 0; m < TABLE_MODES; m++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               k = PRESET_K[m][r][c];
               t[m][r][c] = COEF_W'(((k << COEF_FRAC_BITS) + 500) / 1000);
            end
         end
      end
      return t;
   endfunction

   function automatic mode_map_type build_mode_map();
      mode_map_type t;
      int idx;
      for (int v = 0; v < 2**MODE_W; v++) begin
         idx = v % MODE_COUNT;
         if (idx >= TABLE_MODES) begin
            idx = idx % TABLE_MODES;
         end
         t[v] = IDX_W'(idx);
      end
      return t;
   endfunction

   localparam coef_table_type COEFS    = build_coefs();
   localparam mode_map_type   MODE_MAP = build_mode_map();

endpackage

@@ hdl/apm_req_if.sv @@
// ----------------------------------------------------------------------------
// apm_req_if
// Request channel: one left and one right RGB888 pixel per transfer.
// ----------------------------------------------------------------------------
interface apm_req_if;
   import apm_pkg::*;

   logic     valid;
   logic     ready;
   chan_type left_red;
   chan_type left_green;
   chan_type left_blue;
   chan_type right_red;
   chan_type right_green;
   chan_type right_blue;

   modport source (
      output valid, left_red, left_green, left_blue,
      output right_red, right_green, right_blue,
      input  ready
   );

   modport sink (
      input  valid, left_red, left_green, left_blue,
      input  right_red, right_green, right_blue,
      output ready
   );

endinterface

@@ hdl/apm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// apm_rsp_if
// Response channel: one anaglyph RGB888 pixel per transfer.
// ----------------------------------------------------------------------------
interface apm_rsp_if;
   import apm_pkg::*;

   logic     valid;
   logic     ready;
   chan_type out_red;
   chan_type out_green;
   chan_type out_blue;

   modport source (
      output valid, out_red, out_green, out_blue,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue,
      output ready
   );

endinterface

@@ hdl/anaglyph_pixel_mixer.sv @@
// ----------------------------------------------------------------------------
// anaglyph_pixel_mixer
// Stereo RGB888 pair in, anaglyph RGB888 pixel out, preset color matrices.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one left and one right camera pixel per request; rsp_chan
//   returns one mixed pixel per request, in order. Both use valid/ready.
//   csr_we/csr_index/csr_wdata write mode (index 0, reduced modulo the preset
//   count) and swap_eyes (index 1); write them only while no request is in
//   flight.
//   Path: an accepted request goes into the input register, then its mixed
//   result into the result register, where rsp_chan offers it. Throughput:
//   1 request per cycle while rsp_chan does not stall; the three row
//   multiply-add-clip units sit between the two registers.
//   Reset (synchronous) empties both stages and sets mode 0 (pass-through),
//   swap off.
//   When the receiver stalls the result register holds; the input register
//   still takes one more request, then req_chan.ready drops until rsp_chan
//   drains.
// ----------------------------------------------------------------------------
module anaglyph_pixel_mixer (
   input  logic                  clock,
   input  logic                  reset,
   apm_req_if.sink               req_chan,
   apm_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  apm_pkg::csr_idx_type  csr_index,
   input  apm_pkg::csr_data_type csr_wdata
);
   import apm_pkg::*;

   cfg_type   cfg;
   logic      req_accept;
   logic      s2_load;
   logic      s1_valid_ff, s1_valid_in;
   logic      s2_valid_ff, s2_valid_in;
   pixel_type left_ff, left_in;
   pixel_type right_ff, right_in;
   pixel_type mix_ff, mix_in;
   pixel_type lsrc, rsrc;
   midx_type  mode_idx;
   preset_type coef_sel;

   apm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // handshake
   assign s2_load        = !s2_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s2_load;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign s1_valid_in = req_accept ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   assign left_in  = req_accept ? {req_chan.left_blue, req_chan.left_green, req_chan.left_red}
                                : left_ff;
   assign right_in = req_accept ? {req_chan.right_blue, req_chan.right_green,
                                   req_chan.right_red}
                                : right_ff;

   // mixing between the registers
   assign mode_idx = MODE_MAP[cfg.mode];
   assign coef_sel = COEFS[mode_idx];
   assign lsrc     = cfg.swap_eyes ? right_ff : left_ff;
   assign rsrc     = cfg.swap_eyes ? left_ff  : right_ff;

   apm_row u_row_red (
      .px     (lsrc),
      .coef   (coef_sel[0]),
      .result (mix_in[0])
   );

   apm_row u_row_green (
      .px     (rsrc),
      .coef   (coef_sel[1]),
      .result (mix_in[1])
   );

   apm_row u_row_blue (
      .px     (rsrc),
      .coef   (coef_sel[2]),
      .result (mix_in[2])
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      if (s2_load && s1_valid_ff) begin
         mix_ff <= mix_in;
      end
   end

   assign rsp_chan.valid     = s2_valid_ff;
   assign rsp_chan.out_red   = mix_ff[0];
   assign rsp_chan.out_green = mix_ff[1];
   assign rsp_chan.out_blue  = mix_ff[2];

   // assertions
   a_reset_empty: assert property (@(posedge clock) reset |=> !s2_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request lost at input register");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load) |=> s2_valid_ff)
      else $error("stage 1 result not moved to output");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && s2_valid_ff && !rsp_chan.ready))
      else $error("request stalled without full pipeline");

   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load && mode_idx == '0 && !cfg.swap_eyes)
      |=> rsp_chan.out_red == $past(left_ff[0]) && rsp_chan.out_blue == $past(right_ff[2]))
      else $error("mode 0 does not pass pixels through");

endmodule

@@ hdl/apm_csr.sv @@
// ----------------------------------------------------------------------------
// apm_csr
// Configuration registers: preset mode and eye swap.
// ----------------------------------------------------------------------------
module apm_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  apm_pkg::csr_idx_type  csr_index,
   input  apm_pkg::csr_data_type csr_wdata,
   output apm_pkg::cfg_type      cfg
);
   import apm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MODE: cfg_in.mode      = csr_wdata[MODE_W-1:0];
            REG_SWAP: cfg_in.swap_eyes = csr_wdata[0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/apm_row.sv @@
// ----------------------------------------------------------------------------
// apm_row
// One matrix row: three rounded products summed and clipped to 8 bits.
// ----------------------------------------------------------------------------
module apm_row (
   input  apm_pkg::pixel_type px,
   input  apm_pkg::row_type   coef,
   output apm_pkg::chan_type  result
);
   import apm_pkg::*;

   logic [PROD_W-1:0] prod [3];
   chan_type          term [3];
   logic [SUM_W-1:0]  sum;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // each product rounds on its own, half up
         prod[i] = PROD_W'(px[i]) * PROD_W'(coef[i]) + ROUND_HALF;
         term[i] = prod[i][COEF_FRAC_BITS +: CHAN_W];
      end
      sum = SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2]);
   end

   assign result = (sum > CHAN_MAX) ? CHAN_MAX[CHAN_W-1:0] : sum[CHAN_W-1:0];

endmodule

@@ tb/tb_anaglyph_pixel_mixer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_anaglyph_pixel_mixer
// Self-checking bench for the anaglyph mixer. Stereo pixel pairs go in
// through the request channel. A local color-matrix predictor builds the
// expected anaglyph pixel for each accepted request. Each result pixel is
// checked in order against it. Both channels idle and stall at random. Mode
// and swap are rewritten between phases, and every mode encoding is used,
// the wrapped ones too.
// ----------------------------------------------------------------------------
module tb_anaglyph_pixel_mixer;
   import apm_pkg::*;

   localparam int PRESETS        = 12;
   localparam int Q_BITS         = 10;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int TAIL_CYCLES    = 8;
   localparam int PHASE_ITEMS    = 38;
   localparam int BURST_ITEMS    = 16;

   localparam int PRESET_GRAY = 2;
   localparam int PRESET_OPT  = 4;
   localparam int PRESET_MIX  = 11;
   localparam int MODE_TOP    = 2**MODE_W - 1;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } rgb_type;

   // weights in thousandths per preset: left red, right green, right blue rows
   localparam int ROW_K [PRESETS][3][3] = '{
      '{'{1000, 0, 0},    '{0, 1000, 0},    '{0, 0, 1000}},
      '{'{299, 587, 114}, '{0, 0, 0},       '{299, 587, 114}},
      '{'{299, 587, 114}, '{299, 587, 114}, '{299, 587, 114}},
      '{'{299, 587, 114}, '{0, 1000, 0},    '{0, 0, 1000}},
      '{'{0, 700, 300},   '{0, 1000, 0},    '{0, 0, 1000}},
      '{'{0, 0, 0},       '{0, 0, 0},       '{0, 0, 1000}},
      '{'{0, 0, 0},       '{0, 1000, 0},    '{0, 0, 0}},
      '{'{1000, 0, 0},    '{0, 1000, 0},    '{0, 0, 0}},
      '{'{1000, 0, 0},    '{0, 0, 0},       '{0, 0, 1000}},
      '{'{0, 0, 0},       '{0, 0, 0},       '{0, 0, 1000}},
      '{'{299, 587, 114}, '{100, 100, 100}, '{299, 587, 114}},
      '{'{299, 587, 114}, '{300, 300, 300}, '{299, 587, 114}}
   };

   logic         clock;
   logic         reset;
   logic         csr_we;
   csr_idx_type  csr_index;
   csr_data_type csr_wdata;

   apm_req_if req_bus ();
   apm_rsp_if rsp_bus ();

   anaglyph_pixel_mixer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mode_type mix_mode = '0;
   logic     mix_swap = 1'b0;
   rgb_type  pixels_due [$];
   rgb_type  oldest_pixel;
   int       error_count = 0;
   int       idle_cycles = 0;
   bit       req_up      = 1'b0;
   bit       req_steady  = 1'b0;
   bit       rsp_steady  = 1'b0;

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---- predictor --------------------------------------------------------

   function automatic int q10(int k);
      return ((k << Q_BITS) + 500) / 1000;
   endfunction

   // each product rounds half up on its own, then the sum clips at 255
   function automatic chan_type row_mix(int m, int r, rgb_type src);
      int acc;
      int ch [3];
      ch[0] = src.red;
      ch[1] = src.green;
      ch[2] = src.blue;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         acc += (ch[i] * q10(ROW_K[m][r][i]) + (1 << (Q_BITS - 1))) >> Q_BITS;
      end
      return (acc > 255) ? chan_type'(255) : chan_type'(acc);
   endfunction

   function automatic rgb_type mix_pair(rgb_type cam_l, rgb_type cam_r);
      int      m;
      rgb_type l_eye;
      rgb_type r_eye;
      rgb_type res;
      m = int'(mix_mode) % PRESETS;
      l_eye = mix_swap ? cam_r : cam_l;
      r_eye = mix_swap ? cam_l : cam_r;
      res.red   = row_mix(m, 0, l_eye);
      res.green = row_mix(m, 1, r_eye);
      res.blue  = row_mix(m, 2, r_eye);
      return res;
   endfunction

   // ---- stimulus helpers -------------------------------------------------

   function automatic rgb_type rgb(chan_type r, chan_type g, chan_type b);
      rgb_type p;
      p.red   = r;
      p.green = g;
      p.blue  = b;
      return p;
   endfunction

   function automatic chan_type pick_chan();
      case ($urandom_range(0, 9))
         0: return chan_type'(0);
         1: return chan_type'(255);
         default: return chan_type'($urandom);
      endcase
   endfunction

   function automatic rgb_type pick_rgb();
      chan_type g;
      if ($urandom_range(0, 7) == 0) begin
         g = pick_chan();
         return rgb(g, g, g);
      end
      return rgb(pick_chan(), pick_chan(), pick_chan());
   endfunction

   task automatic report_error(string what);
      $display("%0t ERROR %s", $time, what);
      error_count++;
   endtask

   // valid stays high across back-to-back requests
   task automatic send_pair(rgb_type cam_l, rgb_type cam_r);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         if (req_up) begin
            req_bus.valid <= 1'b0;
            req_up = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.left_red    <= cam_l.red;
      req_bus.left_green  <= cam_l.green;
      req_bus.left_blue   <= cam_l.blue;
      req_bus.right_red   <= cam_r.red;
      req_bus.right_green <= cam_r.green;
      req_bus.right_blue  <= cam_r.blue;
      req_up = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pixels_due = {pixels_due, mix_pair(cam_l, cam_r)};
   endtask

   task automatic drain_pixels();
      if (req_up) begin
         req_bus.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (pixels_due.size() != 0) @(posedge clock);
   endtask

   // only the low bit of the swap data counts
   task automatic set_mix(csr_data_type mode_val, csr_data_type swap_val);
      drain_pixels();
      csr_we    <= 1'b1;
      csr_index <= REG_MODE;
      csr_wdata <= mode_val;
      @(posedge clock);
      csr_index <= REG_SWAP;
      csr_wdata <= swap_val;
      @(posedge clock);
      csr_we <= 1'b0;
      mix_mode = mode_type'(mode_val);
      mix_swap = swap_val[0];
   endtask

   // ---- tests ------------------------------------------------------------

   task automatic test_reset_passthrough();
      send_pair(rgb(8'h00, 8'h00, 8'h00), rgb(8'h00, 8'h00, 8'h00));
      send_pair(rgb(8'hFF, 8'hFF, 8'hFF), rgb(8'hFF, 8'hFF, 8'hFF));
      send_pair(rgb(8'hFF, 8'hFF, 8'hFF), rgb(8'h00, 8'h00, 8'h00));
      send_pair(rgb(8'h00, 8'h00, 8'h00), rgb(8'hFF, 8'hFF, 8'hFF));
      send_pair(rgb(8'h55, 8'hAA, 8'h55), rgb(8'hAA, 8'h55, 8'hAA));
      send_pair(rgb(8'hAA, 8'h55, 8'hAA), rgb(8'h55, 8'hAA, 8'h55));
      send_pair(rgb(8'h01, 8'h80, 8'h7F), rgb(8'hFE, 8'h7F, 8'h80));
   endtask

   // encodings past the preset count fold back onto the table
   task automatic test_mode_wrap();
      for (int m = PRESETS; m <= MODE_TOP; m++) begin
         set_mix(csr_data_type'(m), csr_data_type'(4'hE));
         send_pair(rgb(8'hFF, 8'hFF, 8'hFF), rgb(8'hFF, 8'hFF, 8'hFF));
         send_pair(rgb(8'h10, 8'h80, 8'hF0), rgb(8'hF0, 8'h80, 8'h10));
      end
   endtask

   task automatic test_swap_and_luma();
      set_mix(csr_data_type'(PRESET_GRAY), csr_data_type'(1));
      send_pair(rgb(8'hFF, 8'h00, 8'h00), rgb(8'h00, 8'h00, 8'hFF));
      send_pair(rgb(8'hFF, 8'hFF, 8'hFF), rgb(8'hFF, 8'hFF, 8'hFF));
      send_pair(rgb(8'h00, 8'hFF, 8'h00), rgb(8'h80, 8'h80, 8'h80));
      set_mix(csr_data_type'(PRESET_OPT), csr_data_type'(4'hF));
      send_pair(rgb(8'h12, 8'hFF, 8'hFF), rgb(8'h34, 8'h56, 8'h78));
      send_pair(rgb(8'hFF, 8'h00, 8'h00), rgb(8'h00, 8'hFF, 8'hFF));
      set_mix(csr_data_type'(PRESET_MIX), csr_data_type'(1));
      send_pair(rgb(8'hFF, 8'hFF, 8'hFF), rgb(8'hFF, 8'hFF, 8'hFF));
      send_pair(rgb(8'h9C, 8'h3D, 8'hE1), rgb(8'h00, 8'h7F, 8'hFF));
   endtask

   task automatic test_random_sweep();
      for (int m = 0; m <= MODE_TOP; m++) begin
         for (int s = 0; s < 2; s++) begin
            set_mix(csr_data_type'(m), csr_data_type'({$urandom_range(0, 7), s[0]}));
            req_steady = ($urandom_range(0, 3) == 0);
            rsp_steady = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) send_pair(pick_rgb(), pick_rgb());
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // back-to-back burst, full stop until the pipe empties, then another burst
   task automatic test_drain_pause();
      set_mix(csr_data_type'($urandom_range(0, MODE_TOP)), csr_data_type'($urandom));
      req_steady = 1'b1;
      repeat (BURST_ITEMS) send_pair(pick_rgb(), pick_rgb());
      drain_pixels();
      repeat (BURST_ITEMS) send_pair(pick_rgb(), pick_rgb());
      req_steady = 1'b0;
   endtask

   // ---- result side ------------------------------------------------------

   initial begin : rsp_pacing
      int stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1 || reset);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pixels_due.size() == 0) begin
            report_error($sformatf("unexpected pixel %h %h %h",
                         rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue));
         end else begin
            oldest_pixel = pixels_due.pop_front();
            if (rsp_bus.out_red !== oldest_pixel.red)
               report_error($sformatf("out_red %h, want %h",
                            rsp_bus.out_red, oldest_pixel.red));
            if (rsp_bus.out_green !== oldest_pixel.green)
               report_error($sformatf("out_green %h, want %h",
                            rsp_bus.out_green, oldest_pixel.green));
            if (rsp_bus.out_blue !== oldest_pixel.blue)
               report_error($sformatf("out_blue %h, want %h",
                            rsp_bus.out_blue, oldest_pixel.blue));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_anaglyph_pixel_mixer: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---- sequence ---------------------------------------------------------

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = REG_MODE;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.left_red    = '0;
      req_bus.left_green  = '0;
      req_bus.left_blue   = '0;
      req_bus.right_red   = '0;
      req_bus.right_green = '0;
      req_bus.right_blue  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_passthrough();
      test_mode_wrap();
      test_swap_and_luma();
      test_random_sweep();
      test_drain_pause();

      drain_pixels();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_anaglyph_pixel_mixer: done, clean");
      end else begin
         $display("tb_anaglyph_pixel_mixer: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/apm_pkg.sv
hdl/apm_req_if.sv
hdl/apm_rsp_if.sv
hdl/apm_csr.sv
hdl/apm_row.sv
hdl/anaglyph_pixel_mixer.sv
tb/tb_anaglyph_pixel_mixer.sv
